// ===== rtl/krt_pkg.sv =====
// Shared types, constants and a helper function of the keyed record table.
`default_nettype none

package krt_pkg;

   // Field widths of one request and one response item.
   localparam int KEY_W          = 32;
   localparam int NAME_W         = 56;
   localparam int SCORE_W        = 32;
   localparam int NAME_MAX_BYTES = NAME_W / 8;

   // Default table geometry.
   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_NAME_BYTES  = 7;

   // Depth of the command queue between the front end and the engine.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_UPDATE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUP       = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      func_type                   func;
      logic signed [KEY_W-1:0]    key;
      logic [NAME_W-1:0]          name_chars;
      logic signed [SCORE_W-1:0]  score_in;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       hit;
      logic [NAME_W-1:0]          name_out;
      logic signed [SCORE_W-1:0]  score_out;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_EXEC,
      BK_FETCH
   } back_state_type;

   // Keep at most nbytes name bytes; the first zero byte ends the name.
   function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] raw,
                                                  input int nbytes);
      logic [NAME_W-1:0] kept;
      logic              alive;
      kept  = '0;
      alive = 1'b1;
      for (int i = 0; i < NAME_MAX_BYTES; i++) begin
         if (i >= nbytes || raw[8*i +: 8] == 8'h00) begin
            alive = 1'b0;
         end
         if (alive) begin
            kept[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return kept;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/krt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module krt_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/krt_front.sv =====
// Front end: accepts request items, trims names and drops unused fields.
`default_nettype none

module krt_front
   import krt_pkg::*;
#(
   parameter int NAME_BYTES = DEF_NAME_BYTES
) (
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    q_full,
   input  wire logic    clearing,
   output logic         push,
   output req_type      push_data
);

   // Hold requests off while the queue is full or the table is being cleared.
   assign req_stall = q_full || clearing;
   assign push      = req_valid && !req_stall;

   // Keep only the fields that the operation uses.
   always_comb begin
      push_data            = req_data;
      push_data.name_chars = '0;
      push_data.score_in   = '0;
      case (req_data.func)
         FUNC_INSERT: begin
            push_data.name_chars = cut_name(req_data.name_chars, NAME_BYTES);
            push_data.score_in   = req_data.score_in;
         end
         FUNC_UPDATE: begin
            push_data.score_in = req_data.score_in;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/krt_queue.sv =====
// Short command queue between the front end and the table engine.
`default_nettype none

module krt_queue
   import krt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         avail,
   output req_type      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/krt_back.sv =====
// Table engine: scans the tag memory for the key, then inserts, deletes, reads or updates.
`default_nettype none

module krt_back
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_avail,
   input  wire req_type q_data,
   output logic         q_pop,
   output logic         clearing,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TAG_W = KEY_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   req_type            cmd_ff, cmd_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               last;
   logic               out_free;
   logic               done;
   logic               tag_hit;
   logic               lookup_hit;
   status_type         status;

   logic               tag_we;
   logic [IDX_W-1:0]   tag_waddr;
   logic [TAG_W-1:0]   tag_wdata;
   logic [TAG_W-1:0]   tag_rdata;
   logic               name_we;
   logic [NAME_W-1:0]  name_rdata;
   logic               score_we;
   logic [IDX_W-1:0]   score_waddr;
   logic [SCORE_W-1:0] score_rdata;

   // Tag memory holds the valid mark above the key.
   krt_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_DEPTH)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (tag_waddr),
      .wdata (tag_wdata),
      .raddr (addr_ff),
      .rdata (tag_rdata)
   );

   krt_ram #(.WIDTH(NAME_W), .DEPTH(TABLE_DEPTH)) u_name_ram (
      .clock (clock),
      .we    (name_we),
      .waddr (free_idx_ff),
      .wdata (cmd_ff.name_chars),
      .raddr (found_idx_ff),
      .rdata (name_rdata)
   );

   krt_ram #(.WIDTH(SCORE_W), .DEPTH(TABLE_DEPTH)) u_score_ram (
      .clock (clock),
      .we    (score_we),
      .waddr (score_waddr),
      .wdata (cmd_ff.score_in),
      .raddr (found_idx_ff),
      .rdata (score_rdata)
   );

   assign last       = (addr_ff == LAST_IDX);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign tag_hit    = tag_rdata[KEY_W] && (tag_rdata[KEY_W-1:0] == cmd_ff.key);
   assign lookup_hit = (cmd_ff.func == FUNC_LOOKUP) && found_ff;
   assign clearing   = (state_ff == BK_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (last) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_avail) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (lookup_hit) begin
               state_in = BK_FETCH;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_FETCH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Result status of the current command from the scan outcome.
   always_comb begin
      case (cmd_ff.func)
         FUNC_INSERT: begin
            if (found_ff) begin
               status = STATUS_DUP;
            end else if (free_ff) begin
               status = STATUS_OK;
            end else begin
               status = STATUS_FULL;
            end
         end
         default: begin
            status = found_ff ? STATUS_OK : STATUS_NOT_FOUND;
         end
      endcase
   end

   // Outputs: queue pop, scan counters, memory writes and the done flag.
   always_comb begin
      q_pop        = 1'b0;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = addr_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      tag_we       = 1'b0;
      tag_waddr    = addr_ff;
      tag_wdata    = '0;
      name_we      = 1'b0;
      score_we     = 1'b0;
      score_waddr  = found_idx_ff;
      done         = 1'b0;

      // Check stage: one tag word arrives per cycle during the scan.
      if (chk_vld_ff) begin
         if (tag_hit && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = chk_idx_ff;
         end
         if (!tag_rdata[KEY_W] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      case (state_ff)
         BK_CLEAR: begin
            tag_we  = 1'b1;
            addr_in = last ? '0 : addr_ff + 1'b1;
         end
         BK_IDLE: begin
            addr_in = '0;
            if (q_avail) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               found_in = 1'b0;
               free_in  = 1'b0;
            end
         end
         BK_SCAN: begin
            chk_vld_in = 1'b1;
            addr_in    = last ? '0 : addr_ff + 1'b1;
         end
         BK_EXEC: begin
            if (out_free && !lookup_hit) begin
               done = 1'b1;
               case (cmd_ff.func)
                  FUNC_INSERT: begin
                     if (!found_ff && free_ff) begin
                        tag_we      = 1'b1;
                        tag_waddr   = free_idx_ff;
                        tag_wdata   = {1'b1, cmd_ff.key};
                        name_we     = 1'b1;
                        score_we    = 1'b1;
                        score_waddr = free_idx_ff;
                     end
                  end
                  FUNC_DELETE: begin
                     if (found_ff) begin
                        tag_we    = 1'b1;
                        tag_waddr = found_idx_ff;
                        tag_wdata = {1'b0, cmd_ff.key};
                     end
                  end
                  FUNC_UPDATE: begin
                     score_we = found_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_FETCH: begin
            done = out_free;
         end
         default: begin
         end
      endcase
   end

   // Output register: loads a finished result, drops it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = status;
         rsp_in.hit       = found_ff;
         rsp_in.name_out  = (state_ff == BK_FETCH) ? name_rdata : '0;
         rsp_in.score_out = (state_ff == BK_FETCH) ? score_rdata : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         addr_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      chk_idx_ff   <= chk_idx_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   // A slot is marked valid only by an insert that found the key absent and a free slot.
   assert property (@(posedge clock) disable iff (reset)
      (tag_we && tag_wdata[KEY_W]) |-> (state_ff == BK_EXEC && free_ff && !found_ff))
      else $error("insert wrote a slot without a clean scan");

   // The memory read for a lookup is taken only after a hit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FETCH) |-> (found_ff && cmd_ff.func == FUNC_LOOKUP))
      else $error("fetch state entered without a lookup hit");

   // The scan pipeline is empty once the command executes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EXEC) |-> !chk_vld_ff)
      else $error("scan still in flight at execute");

   // A matching tag seen by the check stage is recorded.
   assert property (@(posedge clock) disable iff (reset)
      (chk_vld_ff && tag_hit) |=> found_ff)
      else $error("key match lost by the scan");

   // No command leaves the queue and no response is valid during the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> (!q_pop && !rsp_valid_ff))
      else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/keyed_record_table_top.sv =====
// Keyed record table: insert, delete, lookup and score update over a scanned table.
//
// Each request item does one operation on a table of TABLE_DEPTH records. The engine
// scans the tag memory one entry per cycle; a lookup that hits needs one more memory
// read for name and score. A two-entry command queue lets new items be accepted while
// the engine is busy. The result register holds a finished response while the engine
// scans for the next item, but a response that is still waiting holds the engine at its
// final step. After reset a clearing pass over every entry empties the table; requests
// are stalled until it ends. Names keep at most NAME_BYTES bytes, cut at the first zero.
`default_nettype none

module keyed_record_table_top
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    push;
   req_type push_data;
   logic    q_full;
   logic    q_avail;
   logic    q_pop;
   req_type q_data;
   logic    clearing;

   krt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .clearing  (clearing),
      .push      (push),
      .push_data (push_data)
   );

   krt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .avail     (q_avail),
      .pop_data  (q_data)
   );

   krt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_avail   (q_avail),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
